/* hw/rtl/overwriting_ring_queue_assert.svh */
// Assertion macros for the overwriting ring queue checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef OVERWRITING_RING_QUEUE_ASSERT_SVH
`define OVERWRITING_RING_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ORQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ORQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/orq_pkg.sv */
// Package for the overwriting ring queue: item types, status group and mode codes.
// Used by every RTL module but orq_mem, by the checker and by the testbench; depends on nothing.
package orq_pkg;

  localparam int MODE_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int CAP_W   = 9;
  localparam int OCC_W   = 9;

  localparam logic [MODE_W-1:0] MODE_PUSH      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK_OLD  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PEEK_NEW  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_AT   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
  } req_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] data;
    logic               found;
    logic               overwrote;
    logic [OCC_W-1:0]   occupancy;
    logic               is_empty;
    logic               is_full;
  } rsp_item_t;

  // Status of one operation, carried from the pointer stage to the output register.
  typedef struct packed {
    logic             found;
    logic             overwrote;
    logic [OCC_W-1:0] occupancy;
    logic             is_empty;
    logic             is_full;
  } orq_meta_t;

endpackage

/* hw/rtl/orq_mem.sv */
// Entry store of the overwriting ring queue: one write port, one registered read port.
// Depends on nothing; contents are undefined until written.
module orq_mem #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32,
  parameter int PTR_W      = 8
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [PTR_W-1:0]      waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [PTR_W-1:0]      raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no read is issued, so a stalled result keeps its entry.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/orq_ctrl.sv */
// Pointer and count stage of the overwriting ring queue: decodes each item,
// drives the entry store's ports and holds the item's status until the result register takes it. Uses orq_pkg.
module orq_ctrl #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32,
  parameter int PTR_W      = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [orq_pkg::CAP_W-1:0] cfg_data,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  orq_pkg::req_item_t     req,
  input  logic                   adv,
  output logic                   s1_valid,
  output orq_pkg::orq_meta_t     s1_meta,
  output logic                   mem_we,
  output logic [PTR_W-1:0]       mem_waddr,
  output logic [DATA_WIDTH-1:0]  mem_wdata,
  output logic                   mem_re,
  output logic [PTR_W-1:0]       mem_raddr
);
  import orq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int AW    = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;

  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] cap_cfg;
  logic             accept;
  logic             found_c;
  logic             over_c;
  logic [AW-1:0]    h_w, t_w, c_w, cap_w, p_w, cfg_w;
  logic [AW-1:0]    head_inc, tail_inc, pos_idx, newest, raddr_w;
  logic [AW-1:0]    sum_h1, sum_t1, sum_hp;
  logic [63:0]      value_wide;

  assign req_stall = s1_valid && !adv;
  assign accept    = req_valid && !req_stall;

  assign h_w   = AW'(head);
  assign t_w   = AW'(tail);
  assign c_w   = AW'(count);
  assign cap_w = AW'(cap);
  assign p_w   = AW'(req.position);
  assign cfg_w = AW'(cfg_data);

  // Each sum stays below twice the capacity wherever it is used, so one conditional subtract wraps.
  assign sum_h1   = h_w + AW'(1);
  assign sum_t1   = t_w + AW'(1);
  assign sum_hp   = h_w + p_w;
  assign head_inc = (sum_h1 >= cap_w) ? sum_h1 - cap_w : sum_h1;
  assign tail_inc = (sum_t1 >= cap_w) ? sum_t1 - cap_w : sum_t1;
  assign pos_idx  = (sum_hp >= cap_w) ? sum_hp - cap_w : sum_hp;
  assign newest   = (t_w == '0) ? cap_w - AW'(1) : t_w - AW'(1);

  // A written capacity of zero acts as one, and one above the depth acts as the depth.
  always_comb begin
    if (cfg_data == '0) begin
      cap_cfg = CNT_W'(1);
    end else if (cfg_w > AW'(DEPTH)) begin
      cap_cfg = CNT_W'(DEPTH);
    end else begin
      cap_cfg = CNT_W'(cfg_w);
    end
  end

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    found_c    = 1'b0;
    over_c     = 1'b0;
    raddr_w    = h_w;
    case (req.mode)
      MODE_PUSH: begin
        tail_next = tail_inc[PTR_W-1:0];
        if (c_w >= cap_w) begin
          over_c    = 1'b1;
          head_next = head_inc[PTR_W-1:0];
        end else begin
          count_next = CNT_W'(c_w + AW'(1));
        end
      end
      MODE_POP: begin
        if (count != '0) begin
          found_c    = 1'b1;
          head_next  = head_inc[PTR_W-1:0];
          count_next = CNT_W'(c_w - AW'(1));
        end
      end
      MODE_PEEK_OLD: begin
        found_c = (count != '0);
      end
      MODE_PEEK_NEW: begin
        found_c = (count != '0);
        raddr_w = newest;
      end
      MODE_READ_AT: begin
        found_c = (p_w < c_w);
        raddr_w = pos_idx;
      end
      MODE_CLEAR: begin
        head_next  = tail;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign value_wide = {32'b0, req.value};
  assign mem_we     = accept && (req.mode == MODE_PUSH);
  assign mem_waddr  = tail;
  assign mem_wdata  = DATA_WIDTH'(value_wide);
  assign mem_re     = accept && found_c;
  assign mem_raddr  = raddr_w[PTR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      cap      <= CNT_W'(DEPTH);
      s1_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        head  <= '0;
        tail  <= '0;
        count <= '0;
        cap   <= cap_cfg;
      end else if (accept) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta.found     <= found_c;
      s1_meta.overwrote <= over_c;
      s1_meta.occupancy <= OCC_W'(count_next);
      s1_meta.is_empty  <= (count_next == '0);
      s1_meta.is_full   <= (count_next == cap);
    end
  end

endmodule

/* hw/rtl/overwriting_ring_queue.sv */
// Top level of the overwriting ring queue: pointer stage, entry store and result register.
// Depends on orq_pkg, orq_ctrl and orq_mem.
//
// The queue takes one operation per item (push, pop, peek oldest, peek newest, read at
// a position from the oldest entry, clear) and returns exactly one result item for each.
// It sustains one item per clock cycle while the result side does not stall; each item is
// registered in the pointer stage and then in the output register. The cycle in which an
// item is accepted decodes it, updates head, tail and count and issues at most one write
// or one read of the entry store at the accepting edge; the store's registered read data
// is then held until the output register can take it, and is captured there. The
// store has one write port and one read port, and since a push writes at one clock
// edge and any later read is issued no earlier than the next edge, a pop or peek right
// after a push sees the new entry with no forwarding. Writing the capacity register
// empties the queue; a written value of zero acts as one and a value above DEPTH acts
// as DEPTH. The store needs no clearing after reset, because only written entries can
// be read. When the result side stalls with a result waiting, a pointer stage holding an
// item keeps it and the input side is stalled in the same cycle.
module overwriting_ring_queue #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [orq_pkg::CAP_W-1:0] cfg_data,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  orq_pkg::req_item_t        req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output orq_pkg::rsp_item_t        rsp
);
  import orq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  logic                  adv;
  logic                  s1_valid;
  orq_meta_t             s1_meta;
  logic                  mem_we;
  logic [PTR_W-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [PTR_W-1:0]      mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic [63:0]           rdata_wide;

  // The result register can take a new item when it is empty or being drained.
  assign adv = !rsp_valid || !rsp_stall;

  orq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .PTR_W      (PTR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .s1_meta   (s1_meta),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr)
  );

  orq_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .PTR_W      (PTR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Stored entries are zero-extended to the data field; data reads as zero when
  // nothing was found.
  assign rdata_wide = 64'(mem_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      rsp.data      <= s1_meta.found ? rdata_wide[VALUE_W-1:0] : '0;
      rsp.found     <= s1_meta.found;
      rsp.overwrote <= s1_meta.overwrote;
      rsp.occupancy <= s1_meta.occupancy;
      rsp.is_empty  <= s1_meta.is_empty;
      rsp.is_full   <= s1_meta.is_full;
    end
  end

endmodule

/* hw/rtl/orq_checker.sv */
// Port-level checker for the overwriting ring queue, bound to the top level.
// Depends on orq_pkg and overwriting_ring_queue_assert.svh.
`include "overwriting_ring_queue_assert.svh"

module orq_checker (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input orq_pkg::rsp_item_t rsp
);
  import orq_pkg::*;

  // A result with nothing found carries zero data.
  `ORQ_ASSERT_NOW(a_data_zero, rsp_valid && !rsp.found, rsp.data == '0, "data set without found")

  // The empty flag agrees with the occupancy.
  `ORQ_ASSERT_NOW(a_empty_occ, rsp_valid, rsp.is_empty == (rsp.occupancy == '0), "empty mismatch")

  // Dropping the oldest entry leaves the queue full and never empty.
  `ORQ_ASSERT_NOW(a_over_full, rsp_valid && rsp.overwrote, rsp.is_full && !rsp.is_empty, "overwrite not full")

  // A stalled result stays in place.
  `ORQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")

endmodule

bind overwriting_ring_queue orq_checker u_orq_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

/* test/orq_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the overwriting ring queue testbench: tracks the queue state
// from the accepted items and compares every accepted result item. Depends on orq_pkg.
module orq_result_checker #(
  parameter int DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [orq_pkg::CAP_W-1:0] cfg_data,
  input  logic                      req_valid,
  input  logic                      req_stall,
  input  orq_pkg::req_item_t        req,
  input  logic                      rsp_valid,
  input  logic                      rsp_stall,
  input  orq_pkg::rsp_item_t        rsp,
  output int                        mismatches,
  output int                        awaiting
);
  import orq_pkg::*;

  localparam int REPORT_LIMIT = 30;

  // Shadow copy of the queue. Slots are never cleared, matching the hardware.
  logic [VALUE_W-1:0] slot_data [DEPTH];
  logic [CAP_W-1:0]   cap_reg;
  int unsigned        oldest_slot;
  int unsigned        free_slot;
  logic [OCC_W-1:0]   held;

  rsp_item_t awaited_results [$];

  function automatic int unsigned cap_in_use();
    if (cap_reg == '0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return cap_reg;
  endfunction

  function automatic int unsigned ring_add(int unsigned a, int unsigned b, int unsigned cap);
    int unsigned s;
    s = a + b;
    return (s >= cap) ? s - cap : s;
  endfunction

  // Applies one operation to the shadow queue and returns the result it should give.
  task automatic apply_operation(input req_item_t op, output rsp_item_t r);
    int unsigned cap;
    int unsigned idx;
    cap = cap_in_use();
    r = '0;
    case (op.mode)
      MODE_PUSH: begin
        if (held >= cap) begin
          r.overwrote = 1'b1;
          oldest_slot = ring_add(oldest_slot, 1, cap);
          held = held - 1'b1;
        end
        slot_data[free_slot] = op.value;
        free_slot = ring_add(free_slot, 1, cap);
        held = held + 1'b1;
      end
      MODE_POP: begin
        if (held != 0) begin
          r.data = slot_data[oldest_slot];
          r.found = 1'b1;
          oldest_slot = ring_add(oldest_slot, 1, cap);
          held = held - 1'b1;
        end
      end
      MODE_PEEK_OLD: begin
        if (held != 0) begin
          r.data = slot_data[oldest_slot];
          r.found = 1'b1;
        end
      end
      MODE_PEEK_NEW: begin
        if (held != 0) begin
          idx = (free_slot == 0) ? cap - 1 : free_slot - 1;
          r.data = slot_data[idx];
          r.found = 1'b1;
        end
      end
      MODE_READ_AT: begin
        if (op.position < held) begin
          idx = ring_add(oldest_slot, op.position, cap);
          r.data = slot_data[idx];
          r.found = 1'b1;
        end
      end
      MODE_CLEAR: begin
        oldest_slot = free_slot;
        held = '0;
      end
      default: begin
      end
    endcase
    r.occupancy = held;
    r.is_empty  = (held == 0);
    r.is_full   = (held == cap);
  endtask

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    rsp_item_t want;
    rsp_item_t next_want;
    if (rst) begin
      cap_reg     = CAP_W'(DEPTH);
      oldest_slot = 0;
      free_slot   = 0;
      held        = '0;
      mismatches  = 0;
      awaited_results.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result with none expected, expected nothing, actual 0x%0h",
                     $time, rsp);
        end else begin
          want = awaited_results.pop_front();
          flag_field("data", want.data, rsp.data);
          flag_field("found", want.found, rsp.found);
          flag_field("overwrote", want.overwrote, rsp.overwrote);
          flag_field("occupancy", want.occupancy, rsp.occupancy);
          flag_field("is_empty", want.is_empty, rsp.is_empty);
          flag_field("is_full", want.is_full, rsp.is_full);
        end
      end
      // A capacity write empties the queue.
      if (cfg_we) begin
        cap_reg     = cfg_data;
        oldest_slot = 0;
        free_slot   = 0;
        held        = '0;
      end
      if (req_valid && !req_stall) begin
        apply_operation(req, next_want);
        awaited_results.push_back(next_want);
      end
    end
    awaiting = awaited_results.size();
  end

endmodule

/* test/overwriting_ring_queue_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the overwriting ring queue: clock, reset, stimulus and verdict.
// Depends on orq_pkg, the overwriting_ring_queue RTL and orq_result_checker.
module overwriting_ring_queue_tb;
  import orq_pkg::*;

  localparam int DEPTH = 256;
  localparam int DATA_WIDTH = 32;

  // Mode codes the block treats as no operation.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  // The limit leaves ample margin over the slowest correct run.
  localparam int CYCLE_LIMIT = 200000;
  // Only the pointer stage and the result register lie behind the input, so a short drain suffices.
  localparam int DRAIN_CYCLES = 8;
  // Length of the one long receiver hold-off that backs the queue up to its input.
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int PHASES = 8;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_data = '0;
  logic       req_valid = 1'b0;
  logic       req_stall;
  req_item_t  req = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  rsp_item_t  rsp;

  int mismatches;
  int awaiting;
  int cycles = 0;
  bit hold_off_wanted = 1'b0;
  bit hold_off_done = 1'b0;

  always #5 clk = ~clk;

  overwriting_ring_queue #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  orq_result_checker #(
    .DEPTH(DEPTH)
  ) result_watch (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .mismatches(mismatches),
    .awaiting(awaiting)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("overwriting_ring_queue_tb: done, errors");
      $finish;
    end
  end

  function automatic req_item_t make_op(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                                        logic [POS_W-1:0] position);
    req_item_t op;
    op.mode = mode;
    op.value = value;
    op.position = position;
    return op;
  endfunction

  // Draws one random operation. The bulk mix is mostly pushes so that a full-size
  // queue fills and then keeps overwriting its oldest entry; the ordinary mix keeps
  // small queues cycling between empty and full.
  function automatic req_item_t random_op(bit bulk);
    req_item_t op;
    int roll;
    roll = $urandom_range(0, 99);
    if (bulk) begin
      if (roll < 85)      op.mode = MODE_PUSH;
      else if (roll < 89) op.mode = MODE_POP;
      else if (roll < 92) op.mode = MODE_PEEK_OLD;
      else if (roll < 95) op.mode = MODE_PEEK_NEW;
      else if (roll < 99) op.mode = MODE_READ_AT;
      else                op.mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
    end else begin
      if (roll < 38)      op.mode = MODE_PUSH;
      else if (roll < 58) op.mode = MODE_POP;
      else if (roll < 66) op.mode = MODE_PEEK_OLD;
      else if (roll < 74) op.mode = MODE_PEEK_NEW;
      else if (roll < 90) op.mode = MODE_READ_AT;
      else if (roll < 95) op.mode = MODE_CLEAR;
      else                op.mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
    end
    op.value = $urandom;
    // Positions mostly fall near the occupancy so that hits and misses both occur.
    if ($urandom_range(0, 3) == 0 || bulk) op.position = POS_W'($urandom_range(0, 255));
    else op.position = POS_W'($urandom_range(0, 15));
    return op;
  endfunction

  // Offers one item and returns right after the clock edge that accepts it. The
  // stall is read just after the edge, so it is the value the block saw there.
  task automatic send(input req_item_t op);
    req <= op;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  // Capacity is only written while the block holds no item in flight.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain_results();
    cfg_data <= cap;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random items in bursts of random length, with random gaps between bursts.
  // A gap of zero joins two bursts, which gives long stretches with no idling.
  task automatic run_random(input int count, input bit bulk);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      for (int i = 0; i < burst && left > 0; i++) begin
        send(random_op(bulk));
        left--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // The receiver stalls on a pattern of its own: segments of random length that
  // are free running, lightly stalled or heavily stalled. Once the bulk phase has
  // begun it also holds off for one long stretch, so the pipeline backs up and
  // the block stalls its input while the sender keeps offering.
  initial begin : receiver
    int kind;
    int span;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_wanted && !hold_off_done) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end
      kind = $urandom_range(0, 2);
      span = $urandom_range(4, 40);
      repeat (span) begin
        case (kind)
          0: rsp_stall <= 1'b0;
          1: rsp_stall <= ($urandom_range(0, 3) == 0);
          default: rsp_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [CAP_W-1:0] phase_cap [PHASES];
    int phase_items [PHASES];
    bit phase_bulk [PHASES];

    // Capacity settings for the random phases: zero (acts as one), the smallest
    // real sizes, two mid sizes, a random small size, all ones (acts as full depth)
    // and a value past the depth.
    phase_cap   = '{9'd0, 9'd1, 9'd2, 9'd5, 9'd16, 9'd0, 9'd511, 9'd300};
    phase_cap[5] = CAP_W'($urandom_range(3, 12));
    phase_items = '{60, 60, 60, 60, 60, 60, 400, 40};
    phase_bulk  = '{0, 0, 0, 0, 0, 0, 1, 0};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed, at the reset capacity: every read on an empty queue finds nothing,
    // the spare modes change nothing, and a position past the count misses.
    send(make_op(MODE_POP, 32'h0, 8'd0));
    send(make_op(MODE_PEEK_OLD, 32'h0, 8'd0));
    send(make_op(MODE_PEEK_NEW, 32'h0, 8'd0));
    send(make_op(MODE_READ_AT, 32'h0, 8'd0));
    send(make_op(MODE_SPARE_LO, 32'hFFFF_FFFF, 8'd255));
    send(make_op(MODE_SPARE_HI, 32'h0, 8'd0));
    send(make_op(MODE_PUSH, 32'hFFFF_FFFF, 8'd255));
    send(make_op(MODE_PEEK_NEW, 32'h0, 8'd0));
    send(make_op(MODE_READ_AT, 32'h0, 8'd255));
    send(make_op(MODE_CLEAR, 32'h0, 8'd0));

    // Directed, with three slots: fill, peek the newest when the tail has wrapped
    // to slot zero, push into a full queue, read around the wrap, drain past empty.
    write_capacity(9'd3);
    send(make_op(MODE_PUSH, 32'h0000_0000, 8'd0));
    send(make_op(MODE_PUSH, 32'h8000_0001, 8'd0));
    send(make_op(MODE_PUSH, 32'h1234_5678, 8'd0));
    send(make_op(MODE_PEEK_NEW, 32'h0, 8'd0));
    send(make_op(MODE_PUSH, 32'hA5A5_A5A5, 8'd0));
    send(make_op(MODE_PEEK_OLD, 32'h0, 8'd0));
    send(make_op(MODE_READ_AT, 32'h0, 8'd2));
    send(make_op(MODE_READ_AT, 32'h0, 8'd3));
    send(make_op(MODE_POP, 32'h0, 8'd0));
    send(make_op(MODE_POP, 32'h0, 8'd0));
    send(make_op(MODE_POP, 32'h0, 8'd0));
    send(make_op(MODE_POP, 32'h0, 8'd0));

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p]);
      if (phase_bulk[p]) hold_off_wanted = 1'b1;
      run_random(phase_items[p], phase_bulk[p]);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaiting == 0) begin
      $display("overwriting_ring_queue_tb: done, clean");
    end else begin
      $display("overwriting_ring_queue_tb: done, errors");
    end
    $finish;
  end

endmodule

/* overwriting_ring_queue.f */
+incdir+hw/rtl
hw/rtl/orq_pkg.sv
hw/rtl/orq_mem.sv
hw/rtl/orq_ctrl.sv
hw/rtl/overwriting_ring_queue.sv
hw/rtl/orq_checker.sv
test/orq_result_checker.sv
test/overwriting_ring_queue_tb.sv
